// ===== rtl/tfdt_pkg.sv =====
// Package for the tile de-duplication table: sizes, kind and status codes,
// controller/datapath command and status structs, and the row mirror helper.
// No dependencies.
package tfdt_pkg;

  localparam int MAX_TILES   = 2048;
  localparam int TILE_WIDTH  = 8;
  localparam int TILE_HEIGHT = 8;
  localparam int PIXEL_BITS  = 4;

  localparam int ROW_BITS   = TILE_WIDTH * PIXEL_BITS;
  localparam int TILE_IDX_W = 11;
  localparam int COUNT_W    = 12;
  localparam int ROW_IDX_W  = $clog2(TILE_HEIGHT);
  localparam int STORE_AW   = $clog2(MAX_TILES) + ROW_IDX_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic row_wr;
    logic clear;
    logic stage_full;
    logic load;
    logic wr;
    logic append_fin;
    logic scan;
    logic publish;
  } tfdt_cmd_t;

  typedef struct packed {
    logic complete;
    logic full;
    logic wr_last;
    logic scan_done;
    logic out_free;
  } tfdt_stat_t;

  function automatic logic [ROW_BITS-1:0] mirror_row(input logic [ROW_BITS-1:0] r);
    logic [ROW_BITS-1:0] o;
    o = '0;
    for (int i = 0; i < TILE_WIDTH; i++) begin
      o[(TILE_WIDTH-1-i)*PIXEL_BITS +: PIXEL_BITS] = r[i*PIXEL_BITS +: PIXEL_BITS];
    end
    return o;
  endfunction

endpackage

// ===== rtl/tfdt_ctrl.sv =====
// Controller for the tile de-duplication table: sequences row capture,
// tile append, lookup scan and result hand-off. Uses tfdt_pkg.
module tfdt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_kind_i,
  input  tfdt_pkg::tfdt_stat_t  stat_i,
  output tfdt_pkg::tfdt_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_APP,
    ST_LOAD_SCAN,
    ST_APPEND,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind_i)
            tfdt_pkg::KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = ST_RESULT;
            end
            tfdt_pkg::KIND_APPEND: begin
              cmd_o.row_wr = 1'b1;
              if (stat_i.complete) begin
                if (stat_i.full) begin
                  cmd_o.stage_full = 1'b1;
                  state_d          = ST_RESULT;
                end else begin
                  state_d = ST_LOAD_APP;
                end
              end
            end
            tfdt_pkg::KIND_LOOKUP: begin
              cmd_o.row_wr = 1'b1;
              if (stat_i.complete) begin
                state_d = ST_LOAD_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOAD_APP: begin
        cmd_o.load = 1'b1;
        state_d    = ST_APPEND;
      end
      ST_LOAD_SCAN: begin
        cmd_o.load = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_APPEND: begin
        cmd_o.wr = 1'b1;
        if (stat_i.wr_last) begin
          cmd_o.append_fin = 1'b1;
          state_d          = ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/tfdt_datapath.sv =====
// Datapath for the tile de-duplication table: row buffer, tile store memory,
// mirrored-match scan pipeline, tile count and output register. Uses tfdt_pkg.
module tfdt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tfdt_pkg::tfdt_cmd_t                 cmd_i,
  output tfdt_pkg::tfdt_stat_t                stat_o,
  input  logic [tfdt_pkg::IN_DATA_W-1:0]      row_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tfdt_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic [1:0]                          out_user_o
);

  localparam int RB = tfdt_pkg::ROW_BITS;
  localparam int TH = tfdt_pkg::TILE_HEIGHT;
  localparam int RW = tfdt_pkg::ROW_IDX_W;
  localparam int TW = tfdt_pkg::TILE_IDX_W;
  localparam int CW = tfdt_pkg::COUNT_W;
  localparam logic [RW-1:0] LAST_ROW = RW'(TH - 1);

  logic [RB-1:0] pend_q [TH];
  logic [RB-1:0] fwd_q  [TH];
  logic [RB-1:0] rev_q  [TH];
  logic [RB-1:0] store_q [tfdt_pkg::STORE_DEPTH];

  logic [RW-1:0] pos_q;
  logic [CW-1:0] count_q;
  logic [RW-1:0] wr_row_q;

  logic [CW-1:0] iss_tile_q;
  logic [RW-1:0] iss_row_q;
  logic          vld_q;
  logic [RW-1:0] tag_row_q;
  logic [TW-1:0] tag_tile_q;
  logic [RB-1:0] rdata_q;
  logic [3:0]    macc_q;

  logic [1:0]    stage_status_q;
  logic [TW-1:0] stage_index_q;
  logic          stage_h_q;
  logic          stage_v_q;

  logic                           out_valid_q;
  logic [tfdt_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [1:0]                     out_user_q;

  logic [RB-1:0] row_in;
  logic          complete;
  logic          issue_en;
  logic          data_en;
  logic [RB-1:0] mrow;
  logic [3:0]    eq;
  logic [3:0]    acc;
  logic          tile_end;
  logic          hit;
  logic          last_tile;
  logic          scan_done;

  assign row_in   = row_i[RB-1:0];
  assign complete = last_i || (pos_q == LAST_ROW);
  assign issue_en = cmd_i.scan && (iss_tile_q < count_q);
  assign data_en  = cmd_i.scan && vld_q;

  assign mrow  = tfdt_pkg::mirror_row(rdata_q);
  assign eq[0] = (rdata_q == fwd_q[0]);
  assign eq[1] = (mrow == fwd_q[0]);
  assign eq[2] = (rdata_q == rev_q[0]);
  assign eq[3] = (mrow == rev_q[0]);
  assign acc   = ((tag_row_q == '0) ? 4'b1111 : macc_q) & eq;

  assign tile_end  = data_en && (tag_row_q == LAST_ROW);
  assign hit       = |acc;
  assign last_tile = ((CW'(tag_tile_q) + CW'(1)) == count_q);
  assign scan_done = cmd_i.scan && ((count_q == '0) || (tile_end && (hit || last_tile)));

  assign stat_o.complete  = complete;
  assign stat_o.full      = (count_q >= CW'(tfdt_pkg::MAX_TILES));
  assign stat_o.wr_last   = (wr_row_q == LAST_ROW);
  assign stat_o.scan_done = scan_done;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      store_q[{count_q[TW-1:0], wr_row_q}] <= fwd_q[0];
    end
    if (issue_en) begin
      rdata_q <= store_q[{iss_tile_q[TW-1:0], iss_row_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_wr) begin
      for (int i = 0; i < TH; i++) begin
        if (RW'(i) == pos_q) begin
          pend_q[i] <= row_in;
        end else if (complete && (RW'(i) > pos_q)) begin
          pend_q[i] <= '0;
        end
      end
    end
    if (cmd_i.load) begin
      for (int i = 0; i < TH; i++) begin
        fwd_q[i] <= pend_q[i];
        rev_q[i] <= pend_q[TH-1-i];
      end
    end else if (cmd_i.wr || data_en) begin
      for (int i = 0; i < TH - 1; i++) begin
        fwd_q[i] <= fwd_q[i+1];
        rev_q[i] <= rev_q[i+1];
      end
      fwd_q[TH-1] <= fwd_q[0];
      rev_q[TH-1] <= rev_q[0];
    end
    if (data_en) begin
      macc_q <= acc;
    end
    if (issue_en) begin
      tag_row_q  <= iss_row_q;
      tag_tile_q <= iss_tile_q[TW-1:0];
    end
    if (cmd_i.clear) begin
      stage_status_q <= tfdt_pkg::STATUS_OK;
      stage_index_q  <= '0;
      stage_h_q      <= 1'b0;
      stage_v_q      <= 1'b0;
    end else if (cmd_i.stage_full) begin
      stage_status_q <= tfdt_pkg::STATUS_FULL;
      stage_index_q  <= '0;
      stage_h_q      <= 1'b0;
      stage_v_q      <= 1'b0;
    end else if (cmd_i.append_fin) begin
      stage_status_q <= tfdt_pkg::STATUS_OK;
      stage_index_q  <= count_q[TW-1:0];
      stage_h_q      <= 1'b0;
      stage_v_q      <= 1'b0;
    end else if (scan_done) begin
      if (tile_end && hit) begin
        stage_status_q <= tfdt_pkg::STATUS_OK;
        stage_index_q  <= tag_tile_q;
        stage_h_q      <= !acc[0] && (acc[1] || (!acc[2] && acc[3]));
        stage_v_q      <= !acc[0] && !acc[1] && (acc[2] || acc[3]);
      end else begin
        stage_status_q <= tfdt_pkg::STATUS_NOT_FOUND;
        stage_index_q  <= '0;
        stage_h_q      <= 1'b0;
        stage_v_q      <= 1'b0;
      end
    end
    if (cmd_i.publish) begin
      out_user_q <= stage_status_q;
      out_data_q <= tfdt_pkg::OUT_DATA_W'({count_q, stage_v_q, stage_h_q, stage_index_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      count_q     <= '0;
      wr_row_q    <= '0;
      iss_tile_q  <= '0;
      iss_row_q   <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        pos_q   <= '0;
        count_q <= '0;
      end else if (cmd_i.row_wr) begin
        pos_q <= complete ? '0 : pos_q + RW'(1);
      end else if (cmd_i.append_fin) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.load) begin
        wr_row_q   <= '0;
        iss_tile_q <= '0;
        iss_row_q  <= '0;
        vld_q      <= 1'b0;
      end else begin
        if (cmd_i.wr) begin
          wr_row_q <= wr_row_q + RW'(1);
        end
        if (cmd_i.scan) begin
          vld_q <= issue_en;
        end
        if (issue_en) begin
          if (iss_row_q == LAST_ROW) begin
            iss_row_q  <= '0;
            iss_tile_q <= iss_tile_q + CW'(1);
          end else begin
            iss_row_q <= iss_row_q + RW'(1);
          end
        end
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(tfdt_pkg::MAX_TILES))
    else $error("tile count above capacity");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append_fin |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not advance tile count");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending beat");

  a_write_scan_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr && cmd_i.scan))
    else $error("store write during scan");

endmodule

// ===== rtl/tile_flip_dedup_table.sv =====
// Tile de-duplication table with mirrored matching; uses tfdt_pkg,
// tfdt_ctrl and tfdt_datapath.
//
// Input beats on s_axis carry one 8x8 tile row each; tuser gives the kind
// (append, lookup, clear), tlast marks the bottom row. Rows that do not
// complete a tile produce no output. A completing append stores the tile
// and returns its index; a completing lookup returns the lowest matching
// index with hflip/vflip; clear empties the table. One result beat per
// completed operation leaves on m_axis (status in tuser).
// Timing: a row that does not complete a tile is only buffered; clear and a
// full-table append go straight to the result; append writes the store
// once per row; lookup scans up to all N stored tiles, bounded by the
// single read port of the tile store scanned one row per cycle.
// One item is handled at a time; s_axis_tready is low while an operation
// runs or while its result waits behind an unaccepted output beat.
// Reset empties the table and the row buffer; no clearing pass is needed.
module tile_flip_dedup_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] row_pixels
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [10:0] tile_index, [11] hflip, [12] vflip,
                                      // [24:13] tile_count, [31:25] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  tfdt_pkg::tfdt_cmd_t  cmd;
  tfdt_pkg::tfdt_stat_t stat;

  tfdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tfdt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .row_i       (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule
